@@ rtl/cmrd_pkg.sv @@
// ----------------------------------------------------------------------------
// cmrd_pkg
// Types and constants shared by the command ring mailbox drain modules.
// ----------------------------------------------------------------------------
package cmrd_pkg;

    localparam int DATA_W = 64;   // width of one command half
    localparam int SLOT_W = 3;    // width of the mailbox slot field

    // function codes of an input word
    localparam logic FUNC_ENQ  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic wr;      // write one command into the ring
        logic rd;      // advance head and read the entry there
        logic first;   // first read of a tick: restart the slot count
        logic load;    // move read data into the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic empty;   // head equals tail
        logic last;    // word in the output register closes the run
    } t_dp_sts;

endpackage

@@ rtl/cmrd_ctrl.sv @@
// ----------------------------------------------------------------------------
// cmrd_ctrl
// Sequencer: takes input words, steps the drain of one tick and drives
// the output handshake.
// ----------------------------------------------------------------------------
module cmrd_ctrl
    import cmrd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_func,
    input  logic    i_partner_busy,
    output logic    o_stall,
    output logic    o_valid,
    input  logic    i_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    if (i_func == FUNC_ENQ) begin
                        o_cmd.wr = 1'b1;
                    end else if (!i_partner_busy && !i_sts.empty) begin
                        o_cmd.rd    = 1'b1;
                        o_cmd.first = 1'b1;
                        n_state     = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.rd = 1'b1;
                        n_state  = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/cmrd_dp.sv @@
// ----------------------------------------------------------------------------
// cmrd_dp
// Datapath: ring memory, head and tail pointers, slot count and the
// output register.
// ----------------------------------------------------------------------------
module cmrd_dp
    import cmrd_pkg::*;
#(
    parameter int RING_DEPTH    = 64,
    parameter int MAILBOX_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [DATA_W-1:0] i_cmd_low,
    input  logic [DATA_W-1:0] i_cmd_high,
    output t_dp_sts           o_sts,
    output logic [SLOT_W-1:0] o_slot,
    output logic [DATA_W-1:0] o_data_low,
    output logic [DATA_W-1:0] o_data_high,
    output logic              o_last
);

    localparam int IW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(MAILBOX_SLOTS + 1);

    logic [2*DATA_W-1:0] r_mem [RING_DEPTH];
    logic [2*DATA_W-1:0] r_rdata;

    logic [IW-1:0] r_head;
    logic [IW-1:0] r_tail;
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_slot_pend;
    logic          r_last_pend;

    logic [SLOT_W-1:0] r_out_slot;
    logic [DATA_W-1:0] r_out_low;
    logic [DATA_W-1:0] r_out_high;
    logic              r_out_last;

    logic [IW-1:0] n_tail;
    logic [IW-1:0] n_head;
    logic [IW-1:0] head_inc;
    logic [CW-1:0] slot_now;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
        ring_next = (idx == IW'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    assign n_tail   = ring_next(r_tail);
    assign head_inc = ring_next(r_head);
    assign slot_now = i_cmd.first ? '0 : r_cnt;

    always_comb begin
        n_head = r_head;
        if (i_cmd.wr && (n_tail == r_head)) begin
            n_head = head_inc;   // drop oldest on a full ring
        end else if (i_cmd.rd) begin
            n_head = head_inc;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            if (i_cmd.wr) begin
                r_tail <= n_tail;
            end
            if (i_cmd.rd) begin
                r_cnt <= slot_now + 1'b1;
            end
        end
    end

    // ring memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_mem[n_tail] <= {i_cmd_high, i_cmd_low};
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[head_inc];
        end
    end

    // tag of the word in flight, then the output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_slot_pend <= slot_now;
            r_last_pend <= (slot_now + 1'b1 == CW'(MAILBOX_SLOTS))
                           || (head_inc == r_tail);
        end
        if (i_cmd.load) begin
            r_out_slot <= SLOT_W'(r_slot_pend);
            r_out_low  <= r_rdata[DATA_W-1:0];
            r_out_high <= r_rdata[2*DATA_W-1:DATA_W];
            r_out_last <= r_last_pend;
        end
    end

    assign o_sts.empty = (r_head == r_tail);
    assign o_sts.last  = r_out_last;
    assign o_slot      = r_out_slot;
    assign o_data_low  = r_out_low;
    assign o_data_high = r_out_high;
    assign o_last      = r_out_last;

endmodule

@@ rtl/command_ring_mailbox_drain.sv @@
// ----------------------------------------------------------------------------
// command_ring_mailbox_drain
// Ring of 16-byte commands drained into mailbox slots for a partner CPU.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one word: an enqueue
//   (i_func = 0) with a 16-byte command, or a service tick (i_func = 1)
//   with the partner busy flag. Output channel (o_valid / i_stall)
//   carries one mailbox write per word: slot, 16 data bytes, last flag.
//   Enqueues stream one per cycle while no drain is running. When the
//   ring is full the oldest unsent command is dropped, so at most
//   RING_DEPTH-1 commands wait.
//   A tick with the partner idle and commands pending copies up to
//   MAILBOX_SLOTS commands, oldest first, to slots 0 upward. Each write
//   passes through a ring memory read, then an output register load,
//   and waits while the receiver stalls; the final write carries o_last.
//   The input stays stalled until that write is taken. A tick that
//   finds the partner busy or the ring empty writes nothing.
//   Reset empties the ring (head = tail = 0) and needs no clearing pass;
//   ring memory contents are left as they are.
// ----------------------------------------------------------------------------
module command_ring_mailbox_drain
    import cmrd_pkg::*;
#(
    parameter int RING_DEPTH    = 64,
    parameter int MAILBOX_SLOTS = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_func,
    input  logic [DATA_W-1:0] i_cmd_low,
    input  logic [DATA_W-1:0] i_cmd_high,
    input  logic              i_partner_busy,
    // output channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SLOT_W-1:0] o_slot,
    output logic [DATA_W-1:0] o_data_low,
    output logic [DATA_W-1:0] o_data_high,
    output logic              o_last
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencer: owns both handshakes
    cmrd_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_func         (i_func),
        .i_partner_busy (i_partner_busy),
        .o_stall        (o_stall),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .i_sts          (dp_sts),
        .o_cmd          (dp_cmd)
    );

    // ring storage, pointers and output word
    cmrd_dp #(
        .RING_DEPTH    (RING_DEPTH),
        .MAILBOX_SLOTS (MAILBOX_SLOTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_cmd_low   (i_cmd_low),
        .i_cmd_high  (i_cmd_high),
        .o_sts       (dp_sts),
        .o_slot      (o_slot),
        .o_data_low  (o_data_low),
        .o_data_high (o_data_high),
        .o_last      (o_last)
    );

endmodule
